### rtl/core/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/tae_pkg.sv
`timescale 1ns / 1ps
package tae_pkg;

  localparam int POWER_WIDTH = 16;
  localparam int SUM_W  = POWER_WIDTH + 3;
  localparam int MW_W   = POWER_WIDTH + 2;
  localparam int LOAD_W = 20;
  localparam int B_W    = (MW_W > LOAD_W) ? MW_W : LOAD_W;
  localparam int DT_W   = 34;
  localparam int MM_W   = (POWER_WIDTH > 16) ? POWER_WIDTH : 16;
  localparam int DIV_W  = 30;

  localparam logic [DIV_W-1:0] NS_PER_S = DIV_W'(1000000000);
  localparam logic [DIV_W-1:0] BASE_K   = DIV_W'(1000);
  localparam logic [DIV_W-1:0] BASE_M   = DIV_W'(1000000);
  localparam logic [8:0]       HALF_UW  = 9'd500;

  localparam logic MODE_READ = 1'b1;

  // Read map
  localparam logic [4:0] SEL_SYS   = 5'd0;
  localparam logic [4:0] SEL_GPU   = 5'd5;
  localparam logic [4:0] SEL_BRD   = 5'd10;
  localparam logic [4:0] SEL_GLI   = 5'd15;
  localparam logic [4:0] SEL_EMI   = 5'd17;
  localparam logic [4:0] SEL_MM    = 5'd19;
  localparam logic [4:0] SEL_TIME  = 5'd25;
  localparam logic [4:0] SEL_LIMIT = 5'd29;

  typedef struct packed {
    logic                   is_read;
    logic [4:0]             sel;
    logic [31:0]            ts;
    logic [29:0]            tn;
    logic [POWER_WIDTH-1:0] cpu;
    logic [POWER_WIDTH-1:0] gpu;
    logic [POWER_WIDTH-1:0] mem;
    logic [POWER_WIDTH-1:0] brd;
    logic [9:0]             gl;
    logic [11:0]            gc;
    logic [19:0]            el;
  } item_t;

  // Carry base of each normalization step: fJ->pJ, pJ->uJ, uJ->mJ, mJ->J
  function automatic logic [DIV_W-1:0] carry_base(input logic [1:0] step);
    logic [DIV_W-1:0] b;
    case (step)
      2'd1:    b = BASE_M;
      default: b = BASE_K;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/tae_front.sv
`timescale 1ns / 1ps
module tae_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  tae_pkg::item_t raw_item,
  output logic          head_valid,
  output tae_pkg::item_t head_item,
  input  logic          head_take
);
  import tae_pkg::*;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr_en, rd_en;
  item_t      cls_item;

  // Classify: mark reads so the back end can branch on one bit
  always_comb begin
    cls_item = raw_item;
    cls_item.is_read = (mode == MODE_READ);
  end

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head_item  = q[rp];
  assign wr_en      = push && !full;
  assign rd_en      = head_take && head_valid;

  // Two-entry transaction queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      if (wr_en && !rd_en) cnt <= cnt + 2'd1;
      else if (!wr_en && rd_en) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q[wp] <= cls_item;
  end

endmodule

### rtl/core/tae_div.sv
`timescale 1ns / 1ps
// Floor quotient and remainder of a signed 64-bit value by one of the carry
// bases. Uses reciprocal multiplication on one 32x32 multiplier: four partial
// products for the quotient estimate, two for the back product, then one
// compare and subtract step. Done pulses as the result is registered.
module tae_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                dividend,
  input  logic [tae_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [63:0]                quot,
  output logic [tae_pkg::DIV_W-1:0]  rem
);
  import tae_pkg::*;

  // floor(2^64 / base) for each carry base
  localparam logic [63:0] RECIP_K = 64'd18446744073709551;
  localparam logic [63:0] RECIP_M = 64'd18446744073709;
  localparam logic [63:0] RECIP_G = 64'd18446744073;
  localparam logic [2:0]  PH_FIX  = 3'd6;

  logic             busy, neg;
  logic [2:0]       ph;
  logic [63:0]      mag, recip, recip_sel, q, qd, diff;
  logic [DIV_W-1:0] d, r;
  logic [127:0]     acc;
  logic [31:0]      fa, fb;
  logic [63:0]      pp;

  // Reciprocal for the requested base
  always_comb begin
    case (divisor)
      BASE_M:   recip_sel = RECIP_M;
      NS_PER_S: recip_sel = RECIP_G;
      default:  recip_sel = RECIP_K;
    endcase
  end

  // Shared multiplier operands per phase
  always_comb begin
    case (ph)
      3'd0: begin
        fa = mag[31:0];
        fb = recip[31:0];
      end
      3'd1: begin
        fa = mag[31:0];
        fb = recip[63:32];
      end
      3'd2: begin
        fa = mag[63:32];
        fb = recip[31:0];
      end
      3'd3: begin
        fa = mag[63:32];
        fb = recip[63:32];
      end
      3'd4: begin
        fa = acc[95:64];
        fb = 32'(d);
      end
      3'd5: begin
        fa = acc[127:96];
        fb = 32'(d);
      end
      default: begin
        fa = 32'd0;
        fb = 32'd0;
      end
    endcase
    pp   = {32'd0, fa} * {32'd0, fb};
    diff = mag - qd;
  end

  // Phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 3'd0;
    end else begin
      done <= busy && !start && (ph == PH_FIX);
      if (start) begin
        busy <= 1'b1;
        ph   <= 3'd0;
      end else if (busy) begin
        if (ph == PH_FIX) busy <= 1'b0;
        else ph <= ph + 3'd1;
      end
    end
  end

  // Estimate is the exact quotient or one below it; one correction fixes it
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[63];
      mag   <= dividend[63] ? (64'd0 - dividend) : dividend;
      recip <= recip_sel;
      d     <= divisor;
      acc   <= '0;
      qd    <= '0;
    end else if (busy) begin
      case (ph)
        3'd0:       acc <= acc + {64'd0, pp};
        3'd1, 3'd2: acc <= acc + {32'd0, pp, 32'd0};
        3'd3:       acc <= acc + {pp, 64'd0};
        3'd4:       qd  <= pp;
        3'd5:       qd  <= qd + {pp[31:0], 32'd0};
        default: begin
          if (diff >= 64'(d)) begin
            q <= acc[127:64] + 64'd1;
            r <= DIV_W'(diff - 64'(d));
          end else begin
            q <= acc[127:64];
            r <= DIV_W'(diff);
          end
        end
      endcase
    end
  end

  // Floor correction for negative dividends
  always_comb begin
    if (!neg) begin
      quot = q;
      rem  = r;
    end else if (r == '0) begin
      quot = 64'd0 - q;
      rem  = '0;
    end else begin
      quot = ~q;
      rem  = d - r;
    end
  end

endmodule

### rtl/core/tae_back.sv
`timescale 1ns / 1ps
module tae_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  tae_pkg::item_t        head_item,
  output logic                  head_take,
  input  logic                  pop,
  output logic                  empty,
  output logic signed [63:0]    read_value,
  output logic [31:0]           samples_seen,
  output logic                  select_error
);
  import tae_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_DGO  = 3'd4;
  localparam logic [2:0] ST_DWT  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state;
  item_t      cur;

  // Accumulated state
  logic [63:0]      en [3][5];
  logic [63:0]      il [2][2];
  logic [MM_W-1:0]  mm [6];
  logic [31:0]      st_sec, fin_sec, count;
  logic [29:0]      st_nsec, fin_nsec;
  logic [POWER_WIDTH-1:0] prev [4];

  // Per-sample working registers
  logic signed [DT_W-1:0] dsec, dns;
  logic [MW_W-1:0]        mw [3];
  logic                   half [3];
  logic [3:0]             idx;
  logic [1:0]             step;
  logic [63:0]            prod;

  // Result slot
  logic        out_valid;
  logic [63:0] out_value;
  logic [31:0] out_cnt;
  logic        out_err;
  logic        pop_ok, slot_free, res_load;

  assign pop_ok       = pop && out_valid;
  assign slot_free    = !out_valid || pop_ok;
  assign empty        = !out_valid;
  assign read_value   = $signed(out_value);
  assign samples_seen = out_cnt;
  assign select_error = out_err;
  assign head_take    = (state == ST_IDLE) && head_valid && slot_free;
  assign res_load     = (head_take && head_item.is_read)
                     || ((state == ST_DONE) && slot_free);

  // Result slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop_ok) begin
      out_valid <= 1'b0;
    end
  end

  // Read selection
  logic [63:0] rd_val;
  logic        rd_err;
  logic [4:0]  s;
  always_comb begin
    s = head_item.sel;
    rd_val = 64'd0;
    rd_err = 1'b0;
    if (s < SEL_GPU)        rd_val = en[0][3'(s - SEL_SYS)];
    else if (s < SEL_BRD)   rd_val = en[1][3'(s - SEL_GPU)];
    else if (s < SEL_GLI)   rd_val = en[2][3'(s - SEL_BRD)];
    else if (s < SEL_EMI)   rd_val = il[0][1'(s - SEL_GLI)];
    else if (s < SEL_MM)    rd_val = il[1][1'(s - SEL_EMI)];
    else if (s < SEL_TIME)  rd_val = 64'(mm[3'(s - SEL_MM)]);
    else if (s < SEL_LIMIT) begin
      case (2'(s - SEL_TIME))
        2'd0:    rd_val = 64'(st_sec);
        2'd1:    rd_val = 64'(st_nsec);
        2'd2:    rd_val = 64'(fin_sec);
        default: rd_val = 64'(fin_nsec);
      endcase
    end else rd_err = 1'b1;
  end

  // Sample preparation: first-sample substitution, elapsed time, averages
  logic [31:0]            fs;
  logic [29:0]            fn;
  logic [POWER_WIDTH-1:0] pv [4];
  logic                   first, borrow;
  logic [SUM_W-1:0]       sum_sys, sum_gpu, sum_brd;
  logic signed [DT_W-1:0] dsec_c, dns_c;
  always_comb begin
    first  = (count == 32'd0);
    fs     = first ? cur.ts : fin_sec;
    fn     = first ? cur.tn : fin_nsec;
    pv[0]  = first ? cur.cpu : prev[0];
    pv[1]  = first ? cur.gpu : prev[1];
    pv[2]  = first ? cur.mem : prev[2];
    pv[3]  = first ? cur.brd : prev[3];
    borrow = (cur.tn < fn);
    dsec_c = $signed({2'b00, cur.ts} - {2'b00, fs} - DT_W'(borrow));
    dns_c  = $signed(DT_W'(cur.tn) - DT_W'(fn) + (borrow ? DT_W'(NS_PER_S) : '0));
    sum_sys = SUM_W'(cur.cpu) + SUM_W'(cur.gpu) + SUM_W'(cur.mem)
            + SUM_W'(pv[0]) + SUM_W'(pv[1]) + SUM_W'(pv[2]);
    sum_gpu = SUM_W'(cur.gpu) + SUM_W'(pv[1]);
    sum_brd = SUM_W'(cur.brd) + SUM_W'(pv[3]);
  end

  // Shared multiplier operands
  logic signed [DT_W-1:0]  ma;
  logic [B_W-1:0]          mb;
  logic signed [DT_W+B_W:0] mfull;
  logic [1:0]              mc;
  logic [1:0]              mt;
  always_comb begin
    mc = idx[3:2];
    mt = idx[1:0];
    if (idx < 4'd12) begin
      ma = mt[1] ? dns : dsec;
      mb = mt[0] ? (half[mc] ? B_W'(HALF_UW) : '0) : B_W'(mw[mc]);
    end else begin
      ma = idx[0] ? dns : dsec;
      mb = idx[1] ? B_W'(cur.el) : B_W'(cur.gl);
    end
    mfull = ma * $signed({1'b0, mb});
  end

  // Carry dividers: three energy chains and two integrals
  logic [63:0]      dvd [5];
  logic [DIV_W-1:0] dvs [5];
  logic [63:0]      dq  [5];
  logic [DIV_W-1:0] dr  [5];
  logic [4:0]       ddone;
  logic             dstart;
  logic [2:0]       lo, hi;
  assign dstart = (state == ST_DGO);
  assign lo     = 3'd4 - 3'(step);
  assign hi     = lo - 3'd1;

  genvar g;
  generate
    for (g = 0; g < 5; g++) begin : g_div
      if (g < 3) begin : g_en
        assign dvd[g] = en[g][lo];
        assign dvs[g] = carry_base(step);
      end else begin : g_il
        assign dvd[g] = il[g-3][1];
        assign dvs[g] = NS_PER_S;
      end
      tae_div u_div (
        .clk      (clk),
        .rst      (rst),
        .start    (dstart),
        .dividend (dvd[g]),
        .divisor  (dvs[g]),
        .done     (ddone[g]),
        .quot     (dq[g]),
        .rem      (dr[g])
      );
    end
  endgenerate

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= 32'd0;
      st_sec    <= '0;
      st_nsec   <= '0;
      fin_sec   <= '0;
      fin_nsec  <= '0;
      for (int c = 0; c < 3; c++)
        for (int k = 0; k < 5; k++) en[c][k] <= '0;
      for (int c = 0; c < 2; c++) begin
        il[c][0] <= '0;
        il[c][1] <= '0;
      end
      for (int k = 0; k < 4; k++) prev[k] <= '0;
      mm[0] <= MM_W'(16'hFFFF);
      mm[1] <= MM_W'(16'hFFFF);
      mm[2] <= MM_W'({POWER_WIDTH{1'b1}});
      mm[3] <= '0;
      mm[4] <= '0;
      mm[5] <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (head_take) begin
            cur <= head_item;
            if (head_item.is_read) begin
              out_value <= rd_val;
              out_err   <= rd_err;
              out_cnt   <= count;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          if (first) begin
            st_sec  <= cur.ts;
            st_nsec <= cur.tn;
          end
          if (MM_W'(cur.gl) < mm[0]) mm[0] <= MM_W'(cur.gl);
          if (MM_W'(cur.gc) < mm[1]) mm[1] <= MM_W'(cur.gc);
          if (MM_W'(cur.gpu) < mm[2]) mm[2] <= MM_W'(cur.gpu);
          if (MM_W'(cur.gl) > mm[3]) mm[3] <= MM_W'(cur.gl);
          if (MM_W'(cur.gc) > mm[4]) mm[4] <= MM_W'(cur.gc);
          if (MM_W'(cur.gpu) > mm[5]) mm[5] <= MM_W'(cur.gpu);
          dsec    <= dsec_c;
          dns     <= dns_c;
          mw[0]   <= sum_sys[SUM_W-1:1];
          mw[1]   <= sum_gpu[SUM_W-1:1];
          mw[2]   <= sum_brd[SUM_W-1:1];
          half[0] <= sum_sys[0];
          half[1] <= sum_gpu[0];
          half[2] <= sum_brd[0];
          if (count != 32'hFFFF_FFFF) count <= count + 32'd1;
          fin_sec  <= cur.ts;
          fin_nsec <= cur.tn;
          prev[0]  <= cur.cpu;
          prev[1]  <= cur.gpu;
          prev[2]  <= cur.mem;
          prev[3]  <= cur.brd;
          idx      <= 4'd0;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= 64'(mfull);
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (idx < 4'd12)
            en[mc][3'({1'b0, mt}) + 3'd1] <= en[mc][3'({1'b0, mt}) + 3'd1] + prod;
          else
            il[idx[1]][idx[0]] <= il[idx[1]][idx[0]] + prod;
          if (idx == 4'd15) begin
            step  <= 2'd0;
            state <= ST_DGO;
          end else begin
            idx   <= idx + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_DGO: state <= ST_DWT;
        ST_DWT: begin
          if (ddone[0]) begin
            for (int c = 0; c < 3; c++) begin
              en[c][lo] <= 64'(dr[c]);
              en[c][hi] <= en[c][hi] + dq[c];
            end
            if (step == 2'd0) begin
              for (int c = 0; c < 2; c++) begin
                il[c][1] <= 64'(dr[c+3]);
                il[c][0] <= il[c][0] + dq[c+3];
              end
            end
            if (step == 2'd3) state <= ST_DONE;
            else begin
              step  <= step + 2'd1;
              state <= ST_DGO;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_value <= 64'd0;
            out_err   <= 1'b0;
            out_cnt   <= count;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/trapezoid_energy_accumulator.sv
`timescale 1ns / 1ps
// Trapezoid energy accumulator.
// Input channel: push/full. A transaction is taken when push is high and full
// low; mode selects a power sample or a read of one stored value by read_select.
// A two-entry queue sits in front, so full rises only when two are waiting.
// Result channel: empty/pop. One result per transaction, in order, held in a
// one-entry result register until popped; the block keeps queueing input while
// a result waits.
// A read pushed into an idle block passes through the queue entry and then the
// result register; reads then flow at one per cycle while pop stays high.
// A sample passes through a setup state, 16 products on one shared multiplier
// (a multiply state and an add state each), then four carry steps on
// reciprocal-multiply constant dividers (one per channel chain and integral,
// in parallel), and a state that loads the result; the next transaction is
// taken once the block is idle again.
// Reset (rst, synchronous) clears the queue, the result slot, all energy digits,
// integrals, timestamps and the sample count, and sets minimums to all ones.
// While pop stays low the result holds; processing stops before writing the next
// result and the input queue fills, then full is raised.
module trapezoid_energy_accumulator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             mode,
  input  logic [31:0]                      time_sec,
  input  logic [29:0]                      time_nsec,
  input  logic [tae_pkg::POWER_WIDTH-1:0]  cpu_power_mw,
  input  logic [tae_pkg::POWER_WIDTH-1:0]  gpu_power_mw,
  input  logic [tae_pkg::POWER_WIDTH-1:0]  mem_power_mw,
  input  logic [tae_pkg::POWER_WIDTH-1:0]  board_power_mw,
  input  logic [9:0]                       gpu_load,
  input  logic [11:0]                      gpu_clock_mhz,
  input  logic [19:0]                      emc_load,
  input  logic [4:0]                       read_select,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [63:0]               read_value,
  output logic [31:0]                      samples_seen,
  output logic                             select_error
);
  import tae_pkg::*;

  item_t raw_item, head_item;
  logic  head_valid, head_take;

  // Pack the transaction
  always_comb begin
    raw_item.is_read = 1'b0;
    raw_item.sel     = read_select;
    raw_item.ts      = time_sec;
    raw_item.tn      = time_nsec;
    raw_item.cpu     = cpu_power_mw;
    raw_item.gpu     = gpu_power_mw;
    raw_item.mem     = mem_power_mw;
    raw_item.brd     = board_power_mw;
    raw_item.gl      = gpu_load;
    raw_item.gc      = gpu_clock_mhz;
    raw_item.el      = emc_load;
  end

  tae_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .raw_item   (raw_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_take  (head_take)
  );

  tae_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_take    (head_take),
    .pop          (pop),
    .empty        (empty),
    .read_value   (read_value),
    .samples_seen (samples_seen),
    .select_error (select_error)
  );

endmodule

### rtl/core/tae_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tae_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             push,
  input logic                             full,
  input logic                             mode,
  input logic [31:0]                      time_sec,
  input logic [29:0]                      time_nsec,
  input logic [tae_pkg::POWER_WIDTH-1:0]  cpu_power_mw,
  input logic [tae_pkg::POWER_WIDTH-1:0]  gpu_power_mw,
  input logic [tae_pkg::POWER_WIDTH-1:0]  mem_power_mw,
  input logic [tae_pkg::POWER_WIDTH-1:0]  board_power_mw,
  input logic [9:0]                       gpu_load,
  input logic [11:0]                      gpu_clock_mhz,
  input logic [19:0]                      emc_load,
  input logic [4:0]                       read_select,
  input logic                             empty,
  input logic                             pop,
  input logic signed [63:0]               read_value,
  input logic [31:0]                      samples_seen,
  input logic                             select_error
);
  // Reset leaves no result and room for input
  `CHK_ALL(a_rst_empty, rst |=> empty, "result pending after reset")
  `CHK_ALL(a_rst_room, rst |=> !full, "queue full after reset")
  // A bad selector never carries a value
  `CHK_RUN(a_err_zero, (!empty && select_error) |-> (read_value == 64'sd0), "error with value")
  // A waiting result holds until popped
  `CHK_RUN(a_hold, (!empty && !pop) |=> (!empty && $stable(read_value)), "result changed")
endmodule

bind trapezoid_energy_accumulator tae_checker u_chk (.*);

### tb/trapezoid_energy_accumulator_tb.sv
`timescale 1ns / 1ps
module trapezoid_energy_accumulator_tb;
  import tae_pkg::*;

  localparam int  NUM_RANDOM = 630;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic mode;
  logic [31:0] time_sec;
  logic [29:0] time_nsec;
  logic [POWER_WIDTH-1:0] cpu_power_mw, gpu_power_mw, mem_power_mw, board_power_mw;
  logic [9:0] gpu_load;
  logic [11:0] gpu_clock_mhz;
  logic [19:0] emc_load;
  logic [4:0] read_select;
  logic empty;
  logic pop;
  logic signed [63:0] read_value;
  logic [31:0] samples_seen;
  logic select_error;

  trapezoid_energy_accumulator uut (.*);

  // Expected result of one transaction
  typedef struct {
    bit [63:0] value;
    bit [31:0] count;
    bit        err;
  } meter_result_t;

  // Energy meter predictor plus store of pending results
  class energy_meter_board;
    bit [63:0] sys_e[5], gpu_e[5], brd_e[5];
    bit [63:0] gl_int[2], el_int[2];
    bit [63:0] mm[6];
    bit [63:0] stamps[4];
    bit [63:0] prev_pw[4];
    bit [31:0] count;
    meter_result_t pending[$];
    int mismatches;

    function new();
      foreach (sys_e[i]) begin
        sys_e[i] = 0; gpu_e[i] = 0; brd_e[i] = 0;
      end
      gl_int = '{0, 0};
      el_int = '{0, 0};
      mm = '{64'hFFFF, 64'hFFFF, (64'd1 << POWER_WIDTH) - 1, 0, 0, 0};
      stamps = '{0, 0, 0, 0};
      prev_pw = '{0, 0, 0, 0};
      count = 0;
      mismatches = 0;
    endfunction

    // Floor quotient of a two's complement value by a positive base
    function bit [63:0] floor_quot(bit [63:0] x, bit [63:0] d);
      bit [63:0] mag;
      if (!x[63]) return x / d;
      mag = -x;
      return -((mag + d - 1) / d);
    endfunction

    function void carry_up(ref bit [63:0] lo, ref bit [63:0] hi, input bit [63:0] base);
      bit [63:0] q;
      q = floor_quot(lo, base);
      hi += q;
      lo -= q * base;
    endfunction

    function void add_energy(ref bit [63:0] d[5], input bit [63:0] sum, dsec, dns);
      bit [63:0] mw, uw;
      mw = sum >> 1;
      uw = sum[0] ? 64'd500 : 64'd0;
      d[1] += dsec * mw;
      d[2] += dsec * uw;
      d[3] += dns * mw;
      d[4] += dns * uw;
      carry_up(d[4], d[3], 1000);
      carry_up(d[3], d[2], 1000000);
      carry_up(d[2], d[1], 1000);
      carry_up(d[1], d[0], 1000);
    endfunction

    function void add_load(ref bit [63:0] g[2], input bit [63:0] load, dsec, dns);
      g[0] += load * dsec;
      g[1] += load * dns;
      carry_up(g[1], g[0], 1000000000);
    endfunction

    // Note an accepted transaction and queue its expected result
    function void note_item(item_t it);
      meter_result_t r;
      bit [63:0] dsec, dns, cpu, gpu, mem, brd;
      r.value = 0;
      r.err = 0;
      if (it.is_read == MODE_READ) begin
        if (it.sel < SEL_GPU) r.value = sys_e[it.sel - SEL_SYS];
        else if (it.sel < SEL_BRD) r.value = gpu_e[it.sel - SEL_GPU];
        else if (it.sel < SEL_GLI) r.value = brd_e[it.sel - SEL_BRD];
        else if (it.sel < SEL_EMI) r.value = gl_int[it.sel - SEL_GLI];
        else if (it.sel < SEL_MM) r.value = el_int[it.sel - SEL_EMI];
        else if (it.sel < SEL_TIME) r.value = mm[it.sel - SEL_MM];
        else if (it.sel < SEL_LIMIT) r.value = stamps[it.sel - SEL_TIME];
        else r.err = 1;
      end else begin
        cpu = it.cpu; gpu = it.gpu; mem = it.mem; brd = it.brd;
        if (count == 0) begin
          stamps = '{it.ts, it.tn, it.ts, it.tn};
          prev_pw = '{cpu, gpu, mem, brd};
        end
        if (it.gl > mm[3]) mm[3] = it.gl;
        if (it.gc > mm[4]) mm[4] = it.gc;
        if (gpu > mm[5]) mm[5] = gpu;
        if (it.gl < mm[0]) mm[0] = it.gl;
        if (it.gc < mm[1]) mm[1] = it.gc;
        if (gpu < mm[2]) mm[2] = gpu;
        dsec = 64'(it.ts) - stamps[2];
        dns = 64'(it.tn) - stamps[3];
        if (64'(it.tn) < stamps[3]) begin
          dsec -= 1;
          dns += 1000000000;
        end
        add_energy(sys_e, cpu + gpu + mem + prev_pw[0] + prev_pw[1] + prev_pw[2], dsec, dns);
        add_energy(gpu_e, gpu + prev_pw[1], dsec, dns);
        add_load(gl_int, 64'(it.gl), dsec, dns);
        add_load(el_int, 64'(it.el), dsec, dns);
        add_energy(brd_e, brd + prev_pw[3], dsec, dns);
        if (count != 32'hFFFFFFFF) count++;
        stamps[2] = it.ts;
        stamps[3] = it.tn;
        prev_pw = '{cpu, gpu, mem, brd};
      end
      r.count = count;
      pending.push_back(r);
    endfunction

    // Compare one popped result with the oldest expectation
    function void check(bit [63:0] value, bit [31:0] cnt, bit err);
      meter_result_t r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%h count=%0d err=%0b", value, cnt, err);
        return;
      end
      r = pending.pop_front();
      if (value !== r.value || cnt !== r.count || err !== r.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value exp %h got %h, count exp %0d got %0d, err exp %0b got %0b",
                   r.value, value, r.count, cnt, r.err, err);
      end
    endfunction
  endclass

  energy_meter_board meter;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;
  longint cycles;
  bit [31:0] last_ts;
  bit [29:0] last_tn;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls and long hold-off
  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      meter.check(read_value, samples_seen, select_error);
  end

  task automatic send_item(item_t it);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    push <= 1;
    mode <= it.is_read;
    read_select <= it.sel;
    time_sec <= it.ts;
    time_nsec <= it.tn;
    cpu_power_mw <= it.cpu;
    gpu_power_mw <= it.gpu;
    mem_power_mw <= it.mem;
    board_power_mw <= it.brd;
    gpu_load <= it.gl;
    gpu_clock_mhz <= it.gc;
    emc_load <= it.el;
    do @(posedge clk); while (full);
    meter.note_item(it);
    @(negedge clk);
  endtask

  function automatic item_t read_item(logic [4:0] sel);
    item_t it;
    it = '0;
    it.is_read = MODE_READ;
    it.sel = sel;
    return it;
  endfunction

  function automatic item_t sample_item(bit [31:0] ts, bit [29:0] tn,
                                        bit [POWER_WIDTH-1:0] pw, bit [9:0] gl,
                                        bit [11:0] gc, bit [19:0] el);
    item_t it;
    it = '0;
    it.is_read = ~MODE_READ;
    it.ts = ts; it.tn = tn;
    it.cpu = pw; it.gpu = pw; it.mem = pw; it.brd = pw;
    it.gl = gl; it.gc = gc; it.el = el;
    return it;
  endfunction

  // Random transaction: some reads; samples mostly forward time, some backward, jumps and odd ns
  function automatic item_t random_item();
    item_t it;
    int pick;
    it = '0;
    it.sel = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 35) begin
      it.is_read = MODE_READ;
      return it;
    end
    it.is_read = ~MODE_READ;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      it.ts = last_ts + $urandom_range(0, 3);
      it.tn = 30'($urandom_range(0, 999999999));
    end else if (pick < 90) begin
      it.ts = last_ts - $urandom_range(0, 3);
      it.tn = 30'($urandom_range(0, 999999999));
    end else if (pick < 95) begin
      it.ts = $urandom;
      it.tn = 30'($urandom_range(0, 999999999));
    end else begin
      it.ts = last_ts + $urandom_range(0, 1);
      it.tn = 30'($urandom_range(0, (1 << 30) - 1));
    end
    it.cpu = POWER_WIDTH'($urandom);
    it.gpu = POWER_WIDTH'($urandom);
    it.mem = POWER_WIDTH'($urandom);
    it.brd = POWER_WIDTH'($urandom);
    it.gl = 10'($urandom_range(0, 1000));
    it.gc = 12'($urandom_range(0, 4095));
    it.el = 20'($urandom_range(0, 1000000));
    last_ts = it.ts;
    last_tn = it.tn;
    return it;
  endfunction

  initial begin
    int phase;
    meter = new();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 0;
    last_ts = 32'd100;
    last_tn = 0;
    rst = 1;
    push = 0;
    mode = 0;
    read_select = 0;
    time_sec = 0;
    time_nsec = 0;
    cpu_power_mw = 0; gpu_power_mw = 0; mem_power_mw = 0; board_power_mw = 0;
    gpu_load = 0; gpu_clock_mhz = 0; emc_load = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset values, first sample, extremes, backward time, odd ns
    send_item(read_item(SEL_MM));
    send_item(read_item(SEL_MM + 2));
    send_item(read_item(SEL_SYS));
    send_item(sample_item(32'd100, 30'd999999999, '1, 10'd1000, 12'd4095, 20'd1000000));
    send_item(read_item(SEL_TIME));
    send_item(read_item(SEL_SYS + 4));
    send_item(sample_item(32'd102, 30'd1, '1, 10'd0, 12'd0, 20'd0));
    send_item(sample_item(32'd102, 30'd2, 16'd1, 10'd1000, 12'd4095, 20'd1000000));
    send_item(read_item(SEL_GPU + 3));
    send_item(sample_item(32'd99, 30'd500, 16'd3, 10'd512, 12'd2048, 20'd524288));
    send_item(read_item(SEL_SYS + 2));
    send_item(read_item(SEL_GLI + 1));
    send_item(sample_item(32'd99, 30'h3FFFFFFF, '1, 10'd7, 12'd9, 20'd11));
    send_item(sample_item(32'hFFFFFFFF, 30'd0, '1, 10'd1000, 12'd1, 20'd1000000));
    send_item(sample_item(32'd0, 30'd0, 16'd0, 10'd1000, 12'd1, 20'd1000000));
    send_item(read_item(SEL_EMI));
    send_item(read_item(SEL_BRD));
    send_item(read_item(SEL_MM + 5));
    send_item(read_item(SEL_TIME + 3));
    send_item(read_item(SEL_LIMIT));
    send_item(read_item(5'd31));
    last_ts = 32'd0;

    // Random phases; the first starts with a long receiver hold-off
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; hold_left = 3000; end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 50; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      repeat (NUM_RANDOM / 4) send_item(random_item());
    end
    push <= 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;

    // Drain, then let the block settle
    while (meter.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (meter.mismatches == 0 && meter.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tae_pkg.sv
rtl/core/tae_front.sv
rtl/core/tae_div.sv
rtl/core/tae_back.sv
rtl/core/trapezoid_energy_accumulator.sv
rtl/core/tae_checker.sv
tb/trapezoid_energy_accumulator_tb.sv
